// ===== rtl/pat_pkg.sv =====
`timescale 1ns / 1ps

package pat_pkg;

  localparam int unsigned TAG_W  = 8;
  localparam int unsigned SEQ_W  = 8;
  localparam int unsigned CODE_W = 8;
  localparam int unsigned FUNC_W = 2;

  // tag value meaning "no tag"; never stored
  localparam logic [TAG_W-1:0] TAG_NONE = 8'hFF;

  typedef enum logic [FUNC_W-1:0] {
    FN_SEND  = 2'd0,
    FN_ACK   = 2'd1,
    FN_QUERY = 2'd2,
    FN_FLUSH = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RESP,
    ST_FLUSH
  } state_t;

  // result item as it is loaded into the output register
  typedef struct packed {
    logic [SEQ_W-1:0]  assigned_seq;
    logic              relay_valid;
    logic [TAG_W-1:0]  relay_tag;
    logic [CODE_W-1:0] relay_code;
    logic              tag_pending;
    logic              last;
  } result_t;

endpackage

// ===== rtl/pending_ack_tracker.sv =====
`timescale 1ns / 1ps

// Pending acknowledgement tracker. Keeps up to TABLE_DEPTH {sequence, tag}
// pairs, oldest first. The operation is chosen by in_tuser: a send bumps the
// 8-bit command sequence, reports it and (tag other than 0xFF) appends a pair,
// dropping the oldest one when full; an ack looks up its sequence, removes the
// first match and relays tag and code; a query reports whether a tag is
// pending; a flush relays every pending pair with the given code, tlast on the
// final one, and empties the table (an empty flush gives no transfer). The
// table is walked by one shared comparator and compacted by one shared
// read/write port under a small sequencer, one entry per cycle, and only one
// item is in work at a time. A send appends its pair directly or, when the
// full table must drop its oldest pair, first compacts the table; an ack
// searches up to the match, then compacts the entries above it; a query
// searches up to the match or the end of the table; a flush loads one relay
// per cycle while the output register is free. A stalled output holds the
// sequencer until the result can be loaded.
// The output register decouples the result side: the block takes the next item
// while a result still waits for out_tready.

module pending_ack_tracker #(
  parameter int unsigned TABLE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] app_tag, [15:8] ack_seq, [23:16] result_code
  input  logic [1:0]  in_tuser,   // [1:0] func

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] assigned_seq, [15:8] relay_tag, [23:16] relay_code
  output logic [1:0]  out_tuser,  // [0] relay_valid, [1] tag_pending
  output logic        out_tlast   // last
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  // control strobes from the sequencer to the datapath
  typedef struct packed {
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_idx;
    logic [pat_pkg::SEQ_W-1:0] wr_seq;
    logic [pat_pkg::TAG_W-1:0] wr_tag;
    logic                     cnt_inc;
    logic                     cnt_dec;
    logic                     cnt_clr;
    logic                     ptr_inc;
    logic                     hit_set;
    logic                     out_load;
  } ctrl_t;

  pat_pkg::state_t state_r, state_nxt;

  // table storage, no reset: only entries below count_r are read
  logic [pat_pkg::SEQ_W-1:0] entry_seq_r [TABLE_DEPTH];
  logic [pat_pkg::TAG_W-1:0] entry_tag_r [TABLE_DEPTH];

  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          ptr_r;
  logic [pat_pkg::SEQ_W-1:0] seq_r;
  logic                      hit_r;
  logic [pat_pkg::TAG_W-1:0] hit_tag_r;

  // latched input item
  pat_pkg::func_t             func_r;
  logic [pat_pkg::TAG_W-1:0]  app_tag_r;
  logic [pat_pkg::SEQ_W-1:0]  ack_seq_r;
  logic [pat_pkg::CODE_W-1:0] code_r;

  // output register
  logic        out_tvalid_r;
  logic [23:0] out_tdata_r;
  logic [1:0]  out_tuser_r;
  logic        out_tlast_r;

  ctrl_t                     ctrl;
  pat_pkg::result_t          res;
  pat_pkg::func_t            in_func;
  logic                      in_fire;
  logic                      out_free;
  logic [IDX_W-1:0]          rd_idx;
  logic [pat_pkg::SEQ_W-1:0] rd_seq;
  logic [pat_pkg::TAG_W-1:0] rd_tag;
  logic                      cmp_hit;
  logic                      scan_more;
  logic                      shift_more;
  logic                      flush_last;
  logic                      tbl_full;

  assign in_func  = pat_pkg::func_t'(in_tuser);
  assign in_tready = (state_r == pat_pkg::ST_IDLE);
  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;
  assign tbl_full = (count_r == DEPTH_C);

  // single read port: compaction reads the entry above the one it fills
  always_comb begin
    if (state_r == pat_pkg::ST_SHIFT) begin
      rd_idx = IDX_W'(ptr_r + CNT_W'(1));
    end else begin
      rd_idx = ptr_r[IDX_W-1:0];
    end
  end

  assign rd_seq = entry_seq_r[rd_idx];
  assign rd_tag = entry_tag_r[rd_idx];

  // shared comparator: sequence for ack, tag for query
  assign cmp_hit = (func_r == pat_pkg::FN_ACK) ? (rd_seq == ack_seq_r)
                                               : (rd_tag == app_tag_r);

  assign scan_more  = (ptr_r < count_r);
  assign shift_more = ({1'b0, ptr_r} + (CNT_W + 1)'(1)) < {1'b0, count_r};
  assign flush_last = ({1'b0, ptr_r} + (CNT_W + 1)'(1)) == {1'b0, count_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pat_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (in_func)
            pat_pkg::FN_SEND: begin
              if ((in_tdata[7:0] != pat_pkg::TAG_NONE) && tbl_full) begin
                state_nxt = pat_pkg::ST_SHIFT;
              end else begin
                state_nxt = pat_pkg::ST_RESP;
              end
            end
            pat_pkg::FN_ACK,
            pat_pkg::FN_QUERY: state_nxt = pat_pkg::ST_SCAN;
            pat_pkg::FN_FLUSH: state_nxt = pat_pkg::ST_FLUSH;
            default:           state_nxt = pat_pkg::ST_IDLE;
          endcase
        end
      end
      pat_pkg::ST_SCAN: begin
        if (!scan_more) begin
          state_nxt = pat_pkg::ST_RESP;
        end else if (cmp_hit) begin
          state_nxt = (func_r == pat_pkg::FN_ACK) ? pat_pkg::ST_SHIFT : pat_pkg::ST_RESP;
        end
      end
      pat_pkg::ST_SHIFT: begin
        if (!shift_more) begin
          state_nxt = pat_pkg::ST_RESP;
        end
      end
      pat_pkg::ST_RESP: begin
        if (out_free) begin
          state_nxt = pat_pkg::ST_IDLE;
        end
      end
      pat_pkg::ST_FLUSH: begin
        if (!scan_more) begin
          state_nxt = pat_pkg::ST_IDLE;
        end else if (out_free && flush_last) begin
          state_nxt = pat_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pat_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl = '0;
    res  = '0;
    unique case (state_r)
      pat_pkg::ST_IDLE: begin
        // append straight away when there is room
        if (in_fire && (in_func == pat_pkg::FN_SEND) &&
            (in_tdata[7:0] != pat_pkg::TAG_NONE) && !tbl_full) begin
          ctrl.wr_en   = 1'b1;
          ctrl.wr_idx  = count_r[IDX_W-1:0];
          ctrl.wr_seq  = seq_r + pat_pkg::SEQ_W'(1);
          ctrl.wr_tag  = in_tdata[7:0];
          ctrl.cnt_inc = 1'b1;
        end
      end
      pat_pkg::ST_SCAN: begin
        if (scan_more) begin
          if (cmp_hit) begin
            ctrl.hit_set = 1'b1;
          end else begin
            ctrl.ptr_inc = 1'b1;
          end
        end
      end
      pat_pkg::ST_SHIFT: begin
        ctrl.wr_en  = 1'b1;
        ctrl.wr_idx = ptr_r[IDX_W-1:0];
        if (shift_more) begin
          ctrl.wr_seq  = rd_seq;
          ctrl.wr_tag  = rd_tag;
          ctrl.ptr_inc = 1'b1;
        end else if (func_r == pat_pkg::FN_SEND) begin
          // oldest dropped, new pair goes in the top slot
          ctrl.wr_seq = seq_r;
          ctrl.wr_tag = app_tag_r;
        end else begin
          ctrl.wr_en   = 1'b0;
          ctrl.cnt_dec = 1'b1;
        end
      end
      pat_pkg::ST_RESP: begin
        ctrl.out_load = out_free;
        res.last      = 1'b1;
        if (func_r == pat_pkg::FN_SEND) begin
          res.assigned_seq = seq_r;
        end
        if ((func_r == pat_pkg::FN_ACK) && hit_r) begin
          res.relay_valid = 1'b1;
          res.relay_tag   = hit_tag_r;
          res.relay_code  = code_r;
        end
        res.tag_pending = (func_r == pat_pkg::FN_QUERY) && hit_r;
      end
      pat_pkg::ST_FLUSH: begin
        if (scan_more && out_free) begin
          ctrl.out_load   = 1'b1;
          ctrl.ptr_inc    = !flush_last;
          ctrl.cnt_clr    = flush_last;
          res.relay_valid = 1'b1;
          res.relay_tag   = rd_tag;
          res.relay_code  = code_r;
          res.last        = flush_last;
        end
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pat_pkg::ST_IDLE;
      count_r      <= '0;
      ptr_r        <= '0;
      seq_r        <= '0;
      hit_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (ctrl.cnt_clr) begin
        count_r <= '0;
      end else if (ctrl.cnt_inc) begin
        count_r <= count_r + CNT_W'(1);
      end else if (ctrl.cnt_dec) begin
        count_r <= count_r - CNT_W'(1);
      end

      if (in_fire) begin
        // a full-table send compacts from the oldest slot
        ptr_r <= '0;
        hit_r <= 1'b0;
        if (in_func == pat_pkg::FN_SEND) begin
          seq_r <= seq_r + pat_pkg::SEQ_W'(1);
        end
      end else begin
        if (ctrl.ptr_inc) begin
          ptr_r <= ptr_r + CNT_W'(1);
        end
        if (ctrl.hit_set) begin
          hit_r <= 1'b1;
        end
      end

      if (ctrl.out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r    <= in_func;
      app_tag_r <= in_tdata[7:0];
      ack_seq_r <= in_tdata[15:8];
      code_r    <= in_tdata[23:16];
    end
    if (ctrl.hit_set) begin
      hit_tag_r <= rd_tag;
    end
    if (ctrl.wr_en) begin
      entry_seq_r[ctrl.wr_idx] <= ctrl.wr_seq;
      entry_tag_r[ctrl.wr_idx] <= ctrl.wr_tag;
    end
    if (ctrl.out_load) begin
      out_tdata_r <= {res.relay_code, res.relay_tag, res.assigned_seq};
      out_tuser_r <= {res.tag_pending, res.relay_valid};
      out_tlast_r <= res.last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count above table depth");

  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pat_pkg::ST_SHIFT) |-> (ptr_r < count_r))
    else $error("compaction pointer outside the table");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("second item taken while one is in work");

  a_flag_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> !(out_tuser_r[0] && out_tuser_r[1]))
    else $error("relay and query answer in one result");

  a_mid_flush_relay: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tlast_r) |-> out_tuser_r[0])
    else $error("non-final result that is not a flush relay");

endmodule
